// File: rtl/core/gss_pkg.sv
// Shared types, codes and helper functions for the gene string store.
package gss_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned POINT_W = 10;
	localparam int unsigned TABLE_W = 56;
	localparam int unsigned SIZE_W  = 7;

	typedef enum logic [2:0] {
		REQ_READ_GENE  = 3'd0,
		REQ_WRITE_GENE = 3'd1,
		REQ_LOAD_WORD  = 3'd2,
		REQ_READ_WORD  = 3'd3,
		REQ_CROSSOVER  = 3'd4
	} req_code_t;

	localparam logic [1:0] CFG_GENE_COUNT = 2'd0;
	localparam logic [1:0] CFG_USE_GRAY   = 2'd1;
	localparam logic [1:0] CFG_SIZE_TABLE = 2'd2;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [2:0]         gene_index;
		logic [2:0]         word_index;
		logic [WORD_W-1:0]  data;
		logic [POINT_W-1:0] point_a;
		logic [POINT_W-1:0] point_b;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] main_out;
		logic [WORD_W-1:0] second_out;
		logic              status;
	} rsp_t;

	// Size of gene k from the packed table, saturated to a full word.
	function automatic logic [SIZE_W-1:0] gene_size(logic [TABLE_W-1:0] tbl, logic [2:0] k);
		logic [SIZE_W-1:0] s;
		s = SIZE_W'(tbl >> (7 * 32'(k)));
		return (s > SIZE_W'(WORD_W)) ? SIZE_W'(WORD_W) : s;
	endfunction

	function automatic logic [WORD_W-1:0] gray_encode(logic [WORD_W-1:0] v);
		return v ^ (v >> 1);
	endfunction

	// Prefix XOR from the top bit down.
	function automatic logic [WORD_W-1:0] gray_decode(logic [WORD_W-1:0] g);
		logic [WORD_W-1:0] r;
		r = g;
		r = r ^ (r >> 1);
		r = r ^ (r >> 2);
		r = r ^ (r >> 4);
		r = r ^ (r >> 8);
		r = r ^ (r >> 16);
		r = r ^ (r >> 32);
		return r;
	endfunction

endpackage

// File: rtl/core/gss_chan_if.sv
// Valid/ready channel interface carrying one payload struct.
interface gss_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/gene_string_store_top.sv
// Gene string store: chromosome code words with gene, word and crossover access.
//
//  Channel   Direction  Payload             Handshake
//  --------  ---------  ------------------  ---------------------------
//  req       in         gss_pkg::req_t      valid/ready
//  rsp       out        gss_pkg::rsp_t      valid/ready
//  cfg_*     in         index + 56b data    write enable, no stall
//
// Word requests, crossovers and bad gene indexes go from acceptance straight to the done
// state, which registers the result and raises rsp.valid; req.ready stays low until then.
// A good gene read or write passes through the sum, low-word, high-word and done states:
// a serial adder walks the size table to find the gene's start, then the two words it may
// span are read one per cycle.
// The store is cleared and the configuration reset to defaults by arst_n. A result waits
// in the output register while the next transaction is taken; only a second finished result waits for rsp.ready.
module gene_string_store_top #(
	parameter int unsigned MAX_GENES  = 8,
	parameter int unsigned CODE_WORDS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [gss_pkg::TABLE_W-1:0]   cfg_data,
	gss_chan_if.sink                      req,
	gss_chan_if.source                    rsp
);

	localparam int unsigned WIDX = (CODE_WORDS > 1) ? $clog2(CODE_WORDS) : 1;
	localparam int unsigned W    = gss_pkg::WORD_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SUM  = 5'b00010,
		ST_LO   = 5'b00100,
		ST_HI   = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;

	logic [3:0]                  gene_count_q;
	logic                        use_gray_q;
	logic [gss_pkg::TABLE_W-1:0] size_table_q;

	logic [W-1:0] store_q [CODE_WORDS];

	gss_pkg::req_t req_q;
	logic          bad_q;
	logic [2:0]    k_q;
	logic [8:0]    acc_q;
	logic [W-1:0]  lo_q;

	gss_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	logic                  accept;
	logic                  finish;
	logic                  is_gene;
	logic                  bad_idx;
	logic [3:0]            rd_addr;
	logic [W-1:0]          rd_data;
	logic [3:0]            lo_word;
	logic [3:0]            hi_word;
	logic [5:0]            offset;
	logic [gss_pkg::SIZE_W-1:0] size_cur;
	logic [gss_pkg::SIZE_W-1:0] size_k;
	logic [W-1:0]          gene_mask;
	logic [W-1:0]          wr_val;
	logic [2*W-1:0]        mask_sh;
	logic [2*W-1:0]        val_sh;
	logic [W-1:0]          new_lo;
	logic [W-1:0]          new_hi;
	logic [W-1:0]          extracted;
	logic [W-1:0]          in_span;
	logic                  we;
	logic [3:0]            waddr;
	logic [W-1:0]          wdata;
	gss_pkg::rsp_t         result;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign finish    = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign is_gene = (req.payload.req_type == gss_pkg::REQ_READ_GENE) ||
		(req.payload.req_type == gss_pkg::REQ_WRITE_GENE);
	assign bad_idx = ({1'b0, req.payload.gene_index} >= gene_count_q) ||
		(32'(req.payload.gene_index) >= MAX_GENES);

	// Gene geometry once the start offset is known.
	assign lo_word  = {1'b0, acc_q[8:6]};
	assign hi_word  = lo_word + 4'd1;
	assign offset   = acc_q[5:0];
	assign size_cur = gss_pkg::gene_size(size_table_q, req_q.gene_index);
	assign size_k   = gss_pkg::gene_size(size_table_q, k_q);

	always_comb begin
		if (size_cur >= gss_pkg::SIZE_W'(W)) begin
			gene_mask = '1;
		end else begin
			gene_mask = ~({W{1'b1}} << size_cur[5:0]);
		end
	end

	always_comb begin
		priority case (1'b1)
			(state_q == ST_LO): rd_addr = lo_word;
			(state_q == ST_HI): rd_addr = hi_word;
			default:            rd_addr = {1'b0, req_q.word_index};
		endcase
	end

	assign rd_data = (32'(rd_addr) < CODE_WORDS) ? store_q[rd_addr[WIDX-1:0]] : '0;

	// Read path: bring the gene down to bit zero across the two words.
	assign extracted = W'({rd_data, lo_q} >> offset) & gene_mask;

	// Write path: place the coded value at its offset across the two words.
	assign wr_val  = use_gray_q ? gss_pkg::gray_encode(req_q.data & gene_mask)
		: (req_q.data & gene_mask);
	assign mask_sh = {{W{1'b0}}, gene_mask} << offset;
	assign val_sh  = {{W{1'b0}}, wr_val} << offset;
	assign new_lo  = (lo_q & ~mask_sh[W-1:0]) | val_sh[W-1:0];
	assign new_hi  = (rd_data & ~mask_sh[2*W-1:W]) | val_sh[2*W-1:W];

	always_comb begin
		logic [gss_pkg::POINT_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < W; i++) begin
			pos        = {1'b0, req_q.word_index, 6'(i)};
			in_span[i] = (pos >= req_q.point_a) && (pos < req_q.point_b);
		end
	end

	always_comb begin
		result = '0;
		unique case (req_q.req_type)
			gss_pkg::REQ_READ_GENE: begin
				result.status = bad_q;
				if (!bad_q) begin
					result.main_out = lo_q;
				end
			end
			gss_pkg::REQ_WRITE_GENE: result.status = bad_q;
			gss_pkg::REQ_LOAD_WORD:  result = '0;
			gss_pkg::REQ_READ_WORD:  result.main_out = rd_data;
			gss_pkg::REQ_CROSSOVER: begin
				result.main_out   = (rd_data & ~in_span) | (req_q.data & in_span);
				result.second_out = (req_q.data & ~in_span) | (rd_data & in_span);
			end
			default: result = '0;
		endcase
	end

	// Single write port into the store.
	always_comb begin
		we    = 1'b0;
		waddr = lo_word;
		wdata = lo_q;
		if ((state_q == ST_HI) && (req_q.req_type == gss_pkg::REQ_WRITE_GENE)) begin
			we    = 32'(hi_word) < CODE_WORDS;
			waddr = hi_word;
			wdata = new_hi;
		end else if (finish && !bad_q &&
				(req_q.req_type == gss_pkg::REQ_WRITE_GENE)) begin
			we    = 32'(lo_word) < CODE_WORDS;
			waddr = lo_word;
			wdata = lo_q;
		end else if (finish && (req_q.req_type == gss_pkg::REQ_LOAD_WORD)) begin
			we    = 32'({1'b0, req_q.word_index}) < CODE_WORDS;
			waddr = {1'b0, req_q.word_index};
			wdata = req_q.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CODE_WORDS; i++) begin
				store_q[i] <= '0;
			end
		end else if (we) begin
			store_q[waddr[WIDX-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gene_count_q <= 4'd1;
			use_gray_q   <= 1'b0;
			size_table_q <= gss_pkg::TABLE_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gss_pkg::CFG_GENE_COUNT: gene_count_q <= cfg_data[3:0];
				gss_pkg::CFG_USE_GRAY:   use_gray_q   <= cfg_data[0];
				gss_pkg::CFG_SIZE_TABLE: size_table_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (is_gene && !bad_idx) ? ST_SUM : ST_DONE;
					end
				end
				ST_SUM: begin
					if (k_q == req_q.gene_index) begin
						state_q <= ST_LO;
					end
				end
				ST_LO:   state_q <= ST_HI;
				ST_HI:   state_q <= ST_DONE;
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Transaction fields and the working registers of the sequencer.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.payload;
			bad_q <= is_gene && bad_idx;
			k_q   <= '0;
			acc_q <= '0;
		end else if ((state_q == ST_SUM) && (k_q != req_q.gene_index)) begin
			acc_q <= acc_q + 9'(size_k);
			k_q   <= k_q + 3'd1;
		end
		if (state_q == ST_LO) begin
			lo_q <= rd_data;
		end else if (state_q == ST_HI) begin
			if (req_q.req_type == gss_pkg::REQ_WRITE_GENE) begin
				lo_q <= new_lo;
			end else begin
				lo_q <= use_gray_q ? gss_pkg::gray_decode(extracted) : extracted;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= result;
		end
	end

endmodule
